>>> hw/rtl/slcd_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the sync/length/checksum deframer
// no dependencies; imported by the deframer unit, its checker and its testbench

package slcd_pkg;

   // sync pair that opens every frame
   localparam logic [7:0] SYNC_A = 8'h55;
   localparam logic [7:0] SYNC_B = 8'hAA;

   // frame buffer bound in bytes and number of known senders
   localparam int BUF_LEN    = 256;
   localparam int NUM_AGENTS = 5;

   // field widths of the result item
   localparam int MASK_W = 5;
   localparam int ID_W   = 3;

   // reset value of the declared frame length
   localparam logic [7:0] LEN_RESET = 8'd15;

   // depth of the result queue, room for the two items of a sync pair
   localparam int RQ_DEPTH = 4;
   localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
   localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

   // input kind carried on tuser
   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // frame status codes
   typedef enum logic [2:0] {
      ST_NONE      = 3'd0,
      ST_OK        = 3'd1,
      ST_BAD_SUM   = 3'd2,
      ST_BAD_ID    = 3'd3,
      ST_TOO_SHORT = 3'd4,
      ST_OVERFLOW  = 3'd5
   } status_type;

   // one result item
   typedef struct packed {
      logic              is_tick_result;
      logic [7:0]        frame_byte;
      logic [7:0]        byte_index;
      logic              last;
      status_type        frame_status;
      logic [ID_W-1:0]   sender_id;
      logic              newly_online;
      logic [MASK_W-1:0] online_mask;
   } result_type;

endpackage

>>> hw/rtl/sync_length_checksum_deframer_unit.sv
`timescale 1ns / 1ps
// byte stream deframer: sync hunt, length, additive checksum, sender liveness
// depends on slcd_pkg

// The block takes one item per clock: a received byte (req_tuser = 0) or a
// liveness tick (req_tuser = 1). Outside a frame it hunts for the pair
// 0x55 0xAA; the third frame byte is the total frame length. Every frame byte
// comes out with its index, and the last one carries a status (ok, bad
// checksum, bad id, too short, overflow). An accepted frame marks its sender
// online; a tick takes senders that sent no report since the previous tick
// offline and returns the online mask. Each item is processed in the cycle it
// is accepted and its results are written into a 4-entry result queue, so an
// item is taken every cycle while the queue has room for two results; the
// sync pair is the only item that yields two results. Results appear on the
// rsp side at the earliest in the cycle after the item is accepted, later when
// older results still wait in the queue. csr_wr_en writes the type byte that
// counts as a liveness report; write it only while the block is idle.

module sync_length_checksum_deframer_unit (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] func
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] frame_byte, [15:8] byte_index,
                                    // [18:16] frame_status, [21:19] sender_id,
                                    // [22] newly_online, [27:23] online_mask,
                                    // [31:28] zero
   output logic        rsp_tlast,   // last
   output logic        rsp_tuser,   // [0] is_tick_result
   // configuration
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data  // info_type
);
   import slcd_pkg::*;

   // configuration register
   logic [7:0] info_type_ff;

   // framing state
   logic       in_frame_ff,  in_frame_in;
   logic [7:0] prev_byte_ff, prev_byte_in;
   logic [8:0] frame_index_ff, frame_index_in;
   logic [7:0] frame_length_ff, frame_length_in;
   logic [7:0] running_sum_ff, running_sum_in;
   logic [7:0] captured_id_ff, captured_id_in;
   logic [7:0] captured_type_ff, captured_type_in;

   // per-sender liveness
   logic [NUM_AGENTS-1:0] sender_online_ff, sender_online_in;
   logic [15:0]           report_count_ff [NUM_AGENTS];
   logic [15:0]           report_count_in [NUM_AGENTS];

   // result queue
   result_type            rq_entry_ff [RQ_DEPTH];
   logic [RQ_PTR_W-1:0]   rq_wr_ptr_ff, rq_rd_ptr_ff;
   logic [RQ_CNT_W-1:0]   rq_count_ff, rq_count_in;

   // item processing
   logic       item_go;
   logic       pop;
   logic [1:0] push_cnt;
   result_type res0, res1;

   logic [7:0] len_eff, id_eff, type_eff;
   logic [8:0] idx_next;
   logic       done, id_ok;
   logic [MASK_W-1:0] mask_now;

   assign req_tready = (rq_count_ff <= RQ_CNT_W'(RQ_DEPTH - 2));
   assign item_go    = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;

   // next state and results of the accepted item
   always_comb begin
      in_frame_in      = in_frame_ff;
      prev_byte_in     = prev_byte_ff;
      frame_index_in   = frame_index_ff;
      frame_length_in  = frame_length_ff;
      running_sum_in   = running_sum_ff;
      captured_id_in   = captured_id_ff;
      captured_type_in = captured_type_ff;
      sender_online_in = sender_online_ff;
      report_count_in  = report_count_ff;
      res0             = '0;
      res1             = '0;
      push_cnt         = 2'd0;
      mask_now         = '0;

      // values as seen after this byte is captured
      len_eff  = (frame_index_ff == 9'd2) ? req_tdata : frame_length_ff;
      id_eff   = (frame_index_ff == 9'd3) ? req_tdata : captured_id_ff;
      type_eff = (frame_index_ff == 9'd4) ? req_tdata : captured_type_ff;
      idx_next = frame_index_ff + 9'd1;
      done     = (idx_next == {1'b0, len_eff});
      id_ok    = (id_eff >= 8'd1) && (id_eff <= 8'(NUM_AGENTS));

      if (item_go) begin
         if (req_tuser == FUNC_TICK) begin
            // liveness tick: drop silent senders, restart report counts
            for (int i = 0; i < NUM_AGENTS; i++) begin
               if (report_count_ff[i] != 16'd0) begin
                  report_count_in[i] = 16'd0;
               end else begin
                  sender_online_in[i] = 1'b0;
               end
            end
            res0.is_tick_result = 1'b1;
            push_cnt            = 2'd1;
         end else if (!in_frame_ff) begin
            // sync hunt
            if (prev_byte_ff == SYNC_A && req_tdata == SYNC_B) begin
               in_frame_in     = 1'b1;
               frame_index_in  = 9'd2;
               running_sum_in  = SYNC_A + SYNC_B;
               prev_byte_in    = 8'd0;
               res0.frame_byte = SYNC_A;
               res0.byte_index = 8'd0;
               res1.frame_byte = SYNC_B;
               res1.byte_index = 8'd1;
               push_cnt        = 2'd2;
            end else begin
               prev_byte_in = req_tdata;
            end
         end else begin
            // byte inside a frame
            frame_length_in  = len_eff;
            captured_id_in   = id_eff;
            captured_type_in = type_eff;
            running_sum_in   = running_sum_ff + req_tdata;
            frame_index_in   = idx_next;
            res0.frame_byte  = req_tdata;
            res0.byte_index  = frame_index_ff[7:0];
            push_cnt         = 2'd1;
            if (done) begin
               in_frame_in = 1'b0;
               res0.last   = 1'b1;
               priority if (len_eff == 8'd3 || len_eff == 8'd4) begin
                  res0.frame_status = ST_TOO_SHORT;
               end else if (running_sum_ff != req_tdata) begin
                  res0.frame_status = ST_BAD_SUM;
               end else if (!id_ok) begin
                  res0.frame_status = ST_BAD_ID;
               end else begin
                  res0.frame_status = ST_OK;
                  res0.sender_id    = id_eff[ID_W-1:0];
                  for (int i = 0; i < NUM_AGENTS; i++) begin
                     if (id_eff == 8'(i + 1)) begin
                        res0.newly_online   = !sender_online_ff[i];
                        sender_online_in[i] = 1'b1;
                        if (type_eff == info_type_ff &&
                            report_count_ff[i] != 16'hFFFF) begin
                           report_count_in[i] = report_count_ff[i] + 16'd1;
                        end
                     end
                  end
               end
            end else if (idx_next >= 9'(BUF_LEN)) begin
               in_frame_in       = 1'b0;
               res0.last         = 1'b1;
               res0.frame_status = ST_OVERFLOW;
            end
         end
      end

      // online mask after this item's update
      for (int i = 0; i < NUM_AGENTS; i++) begin
         if (i < MASK_W) begin
            mask_now[i] = sender_online_in[i];
         end
      end
      res0.online_mask = mask_now;
      res1.online_mask = mask_now;
   end

   // queue fill level
   assign rq_count_in = rq_count_ff + RQ_CNT_W'(push_cnt) - RQ_CNT_W'(pop);

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         info_type_ff     <= 8'd0;
         in_frame_ff      <= 1'b0;
         prev_byte_ff     <= 8'd0;
         frame_index_ff   <= 9'd0;
         frame_length_ff  <= LEN_RESET;
         running_sum_ff   <= 8'd0;
         captured_id_ff   <= 8'd0;
         captured_type_ff <= 8'd0;
         sender_online_ff <= '0;
         for (int i = 0; i < NUM_AGENTS; i++) begin
            report_count_ff[i] <= 16'd0;
         end
         rq_wr_ptr_ff     <= '0;
         rq_rd_ptr_ff     <= '0;
         rq_count_ff      <= '0;
      end else begin
         if (csr_wr_en) begin
            info_type_ff <= csr_wr_data;
         end
         in_frame_ff      <= in_frame_in;
         prev_byte_ff     <= prev_byte_in;
         frame_index_ff   <= frame_index_in;
         frame_length_ff  <= frame_length_in;
         running_sum_ff   <= running_sum_in;
         captured_id_ff   <= captured_id_in;
         captured_type_ff <= captured_type_in;
         sender_online_ff <= sender_online_in;
         report_count_ff  <= report_count_in;
         rq_wr_ptr_ff     <= rq_wr_ptr_ff + RQ_PTR_W'(push_cnt);
         rq_rd_ptr_ff     <= rq_rd_ptr_ff + RQ_PTR_W'(pop);
         rq_count_ff      <= rq_count_in;
      end
   end

   // result queue payload
   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         rq_entry_ff[rq_wr_ptr_ff] <= res0;
      end
      if (push_cnt == 2'd2) begin
         rq_entry_ff[rq_wr_ptr_ff + RQ_PTR_W'(1)] <= res1;
      end
   end

   // result port
   result_type head;
   assign head       = rq_entry_ff[rq_rd_ptr_ff];
   assign rsp_tvalid = (rq_count_ff != '0);
   assign rsp_tlast  = head.last;
   assign rsp_tuser  = head.is_tick_result;
   assign rsp_tdata  = {4'b0, head.online_mask, head.newly_online, head.sender_id,
                        head.frame_status, head.byte_index, head.frame_byte};

endmodule

>>> bench/slcd_deframe_checker.sv
`timescale 1ns / 1ps
// result checker for sync_length_checksum_deframer_unit: follows the deframer
// state from accepted items and compares each result item; depends on slcd_pkg

module slcd_deframe_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,          // [7:0] data_byte
   input  logic        req_tuser,          // [0] func
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,          // [7:0] frame_byte, [15:8] byte_index,
                                           // [18:16] frame_status, [21:19] sender_id,
                                           // [22] newly_online, [27:23] online_mask
   input  logic        rsp_tlast,          // last
   input  logic        rsp_tuser,          // [0] is_tick_result
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   output int          error_count,
   output int          results_seen,
   output int          results_pending
);
   import slcd_pkg::*;

   // tracked deframer state
   logic [7:0]            info_type;
   logic                  in_frame;
   logic [7:0]            prev_byte;
   logic [8:0]            frame_index;
   logic [7:0]            frame_length;
   logic [7:0]            running_sum;
   logic [7:0]            captured_id;
   logic [7:0]            captured_type;
   logic [NUM_AGENTS-1:0] online;
   logic [15:0]           report_count [NUM_AGENTS];

   // result items still to come, oldest first
   result_type results_due [$];

   // queue one expected result, mask taken after the update
   task automatic push_due(input logic tick, input logic [7:0] fbyte, input logic [7:0] idx,
                           input logic lst, input status_type st,
                           input logic [ID_W-1:0] id, input logic fresh);
      result_type r;
      r.is_tick_result = tick;
      r.frame_byte     = fbyte;
      r.byte_index     = idx;
      r.last           = lst;
      r.frame_status   = st;
      r.sender_id      = id;
      r.newly_online   = fresh;
      r.online_mask    = online;
      results_due.push_back(r);
   endtask

   // step the tracked state by one accepted item
   task automatic advance_deframer(input logic func, input logic [7:0] b);
      logic [8:0] idx;
      logic [7:0] sum_before;
      logic       fresh;
      int         s;
      if (func == FUNC_TICK) begin
         // silent senders drop offline, report counts restart
         for (int i = 0; i < NUM_AGENTS; i++) begin
            if (report_count[i] != 16'd0) begin
               report_count[i] = 16'd0;
            end else begin
               online[i] = 1'b0;
            end
         end
         push_due(1'b1, 8'd0, 8'd0, 1'b0, ST_NONE, '0, 1'b0);
      end else if (!in_frame) begin
         // sync hunt
         if (prev_byte == SYNC_A && b == SYNC_B) begin
            in_frame    = 1'b1;
            frame_index = 9'd2;
            running_sum = SYNC_A + SYNC_B;
            prev_byte   = 8'd0;
            push_due(1'b0, SYNC_A, 8'd0, 1'b0, ST_NONE, '0, 1'b0);
            push_due(1'b0, SYNC_B, 8'd1, 1'b0, ST_NONE, '0, 1'b0);
         end else begin
            prev_byte = b;
         end
      end else begin
         idx        = frame_index;
         sum_before = running_sum;
         if (idx == 9'd2) frame_length = b;
         if (idx == 9'd3) captured_id = b;
         if (idx == 9'd4) captured_type = b;
         running_sum = running_sum + b;
         frame_index = idx + 9'd1;
         if (frame_index == {1'b0, frame_length}) begin
            // frame complete, work out the status
            in_frame = 1'b0;
            if (frame_length == 8'd3 || frame_length == 8'd4) begin
               push_due(1'b0, b, idx[7:0], 1'b1, ST_TOO_SHORT, '0, 1'b0);
            end else if (sum_before != b) begin
               push_due(1'b0, b, idx[7:0], 1'b1, ST_BAD_SUM, '0, 1'b0);
            end else if (captured_id < 1 || captured_id > NUM_AGENTS) begin
               push_due(1'b0, b, idx[7:0], 1'b1, ST_BAD_ID, '0, 1'b0);
            end else begin
               s         = captured_id - 1;
               fresh     = !online[s];
               online[s] = 1'b1;
               if (captured_type == info_type && report_count[s] != 16'hFFFF)
                  report_count[s] = report_count[s] + 16'd1;
               push_due(1'b0, b, idx[7:0], 1'b1, ST_OK, captured_id[ID_W-1:0], fresh);
            end
         end else if (frame_index >= BUF_LEN) begin
            in_frame = 1'b0;
            push_due(1'b0, b, idx[7:0], 1'b1, ST_OVERFLOW, '0, 1'b0);
         end else begin
            push_due(1'b0, b, idx[7:0], 1'b0, ST_NONE, '0, 1'b0);
         end
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // watch both channels and the register port
   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         info_type     = 8'd0;
         in_frame      = 1'b0;
         prev_byte     = 8'd0;
         frame_index   = 9'd0;
         frame_length  = LEN_RESET;
         running_sum   = 8'd0;
         captured_id   = 8'd0;
         captured_type = 8'd0;
         online        = '0;
         for (int i = 0; i < NUM_AGENTS; i++) report_count[i] = 16'd0;
         results_due.delete();
      end else begin
         if (csr_wr_en) info_type = csr_wr_data;
         if (req_tvalid && req_tready) advance_deframer(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (results_due.size() == 0) begin
               error_count++;
               $display("%0t ns: unexpected result item, expected none, %s %0h %0b %0b",
                        $time, "actual tdata tlast tuser", rsp_tdata, rsp_tlast,
                        rsp_tuser);
            end else begin
               want = results_due.pop_front();
               check_field("is_tick_result", 32'(want.is_tick_result), 32'(rsp_tuser));
               check_field("frame_byte", 32'(want.frame_byte), 32'(rsp_tdata[7:0]));
               check_field("byte_index", 32'(want.byte_index), 32'(rsp_tdata[15:8]));
               check_field("last", 32'(want.last), 32'(rsp_tlast));
               check_field("frame_status", 32'(want.frame_status),
                           32'(rsp_tdata[18:16]));
               check_field("sender_id", 32'(want.sender_id), 32'(rsp_tdata[21:19]));
               check_field("newly_online", 32'(want.newly_online), 32'(rsp_tdata[22]));
               check_field("online_mask", 32'(want.online_mask), 32'(rsp_tdata[27:23]));
               check_field("tdata padding", 32'd0, 32'(rsp_tdata[31:28]));
            end
         end
      end
      results_pending <= results_due.size();
   end

endmodule

>>> bench/tb_sync_length_checksum_deframer_unit.sv
`timescale 1ns / 1ps
// testbench top for sync_length_checksum_deframer_unit: drives byte and tick
// items and the info_type register; depends on slcd_pkg and slcd_deframe_checker

module tb_sync_length_checksum_deframer_unit;
   import slcd_pkg::*;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic [7:0]  req_tdata   = 8'd0;
   logic        req_tuser   = 1'b0;
   logic        rsp_tready  = 1'b0;
   logic        csr_wr_en   = 1'b0;
   logic [7:0]  csr_wr_data = 8'd0;
   wire         req_tready;
   wire         rsp_tvalid;
   wire  [31:0] rsp_tdata;
   wire         rsp_tlast;
   wire         rsp_tuser;

   int         error_count;
   int         results_seen;
   int         results_pending;
   int         send_idle = 0;
   int         recv_idle = 0;
   int         items_sent = 0;
   int         frames_sent = 0;
   int         ticks_sent = 0;
   logic [7:0] info_type_now = 8'd0;

   sync_length_checksum_deframer_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   slcd_deframe_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .rsp_tuser       (rsp_tuser),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .error_count     (error_count),
      .results_seen    (results_seen),
      .results_pending (results_pending)
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // receiver stalls
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   // one item through the req handshake, with random gaps ahead of it
   task automatic send_item(input logic func, input logic [7:0] b);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= (func == FUNC_TICK) ? 8'($urandom_range(255)) : b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (func == FUNC_TICK) ticks_sent++;
   endtask

   // hold off until every result item has arrived and the block has settled
   task automatic wait_for_results;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_info_type(input logic [7:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en     <= 1'b0;
      info_type_now = v;
   endtask

   // payload bytes lean toward the sync bytes and the extremes
   function automatic logic [7:0] payload_byte();
      unique case ($urandom_range(9))
         0: return SYNC_A;
         1: return SYNC_B;
         2: return 8'h00;
         3: return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // one frame; lengths below three run on to the buffer bound
   task automatic send_frame(input logic [7:0] len, input logic [7:0] id,
                             input logic [7:0] msg_type, input logic bad_sum,
                             input logic with_ticks);
      logic [7:0] fbytes [256];
      logic [7:0] sum;
      int         n;
      fbytes[0] = SYNC_A;
      fbytes[1] = SYNC_B;
      fbytes[2] = len;
      fbytes[3] = id;
      fbytes[4] = msg_type;
      n = (len >= 3) ? int'(len) : BUF_LEN;
      for (int i = 5; i < n; i++) fbytes[i] = payload_byte();
      if (len >= 5) begin
         sum = 8'd0;
         for (int i = 0; i < n - 1; i++) sum = sum + fbytes[i];
         fbytes[n-1] = bad_sum ? (sum ^ 8'($urandom_range(1, 255))) : sum;
      end
      for (int i = 0; i < n; i++) begin
         if (with_ticks && $urandom_range(99) < 2) send_item(FUNC_TICK, 8'h00);
         send_item(FUNC_BYTE, fbytes[i]);
      end
      frames_sent++;
   endtask

   // random traffic: mostly well-formed frames, some ticks and loose bytes
   task automatic random_unit;
      int         r;
      logic [7:0] len;
      logic [7:0] id;
      logic [7:0] msg_type;
      r = $urandom_range(99);
      if (r < 6) begin
         send_item(FUNC_TICK, 8'h00);
      end else if (r < 14) begin
         repeat ($urandom_range(1, 4)) send_item(FUNC_BYTE, payload_byte());
      end else begin
         r = $urandom_range(99);
         if (r < 8) len = 8'($urandom_range(3, 4));
         else if (r < 85) len = 8'($urandom_range(5, 12));
         else len = 8'($urandom_range(13, 40));
         if ($urandom_range(9) < 8) id = 8'($urandom_range(1, NUM_AGENTS));
         else if ($urandom_range(1) == 1) id = 8'd0;
         else id = 8'($urandom_range(NUM_AGENTS + 1, 255));
         msg_type = ($urandom_range(1) == 1) ? info_type_now : 8'($urandom_range(255));
         send_frame(len, id, msg_type, $urandom_range(9) == 0, 1'b1);
      end
   endtask

   // stimulus and verdict
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: loose byte, good frame, both short lengths, bad checksum,
      // tick, unknown sender
      write_info_type(8'h00);
      send_item(FUNC_BYTE, 8'hFF);
      send_frame(8'd6, 8'd1, 8'h00, 1'b0, 1'b0);
      send_frame(8'd3, 8'd2, 8'h00, 1'b0, 1'b0);
      send_frame(8'd4, 8'd5, 8'h00, 1'b0, 1'b0);
      send_frame(8'd5, 8'd2, 8'h00, 1'b1, 1'b0);
      send_item(FUNC_TICK, 8'h00);
      send_frame(8'd5, 8'd6, 8'h00, 1'b0, 1'b0);
      wait_for_results();

      // sender idles less than the receiver; zero length runs to overflow
      write_info_type(8'hFF);
      send_idle = 37;
      recv_idle = 73;
      send_frame(8'd0, 8'd1, 8'hFF, 1'b0, 1'b1);
      while (items_sent < 500) random_unit();
      wait_for_results();

      // roles swapped; longest declared length
      write_info_type(8'($urandom_range(1, 254)));
      send_idle = 73;
      recv_idle = 37;
      send_frame(8'd255, 8'd3, info_type_now, 1'b0, 1'b1);
      while (items_sent < 975) random_unit();
      wait_for_results();

      // no idling; length two runs to overflow
      write_info_type(8'($urandom_range(255)));
      send_idle = 0;
      recv_idle = 0;
      send_frame(8'd2, 8'd4, info_type_now, 1'b0, 1'b1);
      while (items_sent < 1450) random_unit();
      wait_for_results();
      repeat (10) @(posedge clock);

      $display("run covered %0d input items (%0d frames, %0d ticks) and %0d result items,",
               items_sent, frames_sent, ticks_sent, results_seen);
      $display("over four info_type settings and three idle patterns");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/slcd_pkg.sv
hw/rtl/sync_length_checksum_deframer_unit.sv
bench/slcd_deframe_checker.sv
bench/tb_sync_length_checksum_deframer_unit.sv
